// ----- src/ebm_pkg.sv -----
// Shared types and constants for the batched einsum matrix multiply block.
// Used by the controller, the datapath, the float unit and the top level.
// No dependencies.
package ebm_pkg;

	// Build defaults
	localparam int STORE_DEPTH_DEF = 4096;
	localparam int DIM_MAX_DEF     = 64;

	// Fixed field widths
	localparam int WORD_W    = 32;
	localparam int CMD_W     = 2;
	localparam int LADDR_W   = 12;
	localparam int IDX_W     = 6;
	localparam int SIZE_W    = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = 7;
	localparam int WIDE_W    = 40;
	localparam int STRIDE_W  = 14;

	// Input commands
	localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_M = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_C = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_H = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_W = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_N = 3'd6;

	// Layout modes
	localparam logic MODE_BMCHW = 1'b0;
	localparam logic MODE_BCHW  = 1'b1;

	// Index of the last address setup step
	localparam logic [1:0] SETUP_LAST = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_READ,
		ST_MUL1,
		ST_MUL2,
		ST_ADD1,
		ST_ADD2,
		ST_DONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic start;
		logic setup;
		logic read;
		logic mul1;
		logic mul2;
		logic add1;
		logic add2;
		logic finish;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic setup_last;
		logic c_empty;
		logic c_last;
		logic addr_err;
		logic out_busy;
	} dp_stat_t;

endpackage

// ----- src/ebm_ctrl.sv -----
// Sequencing state machine for the batched einsum block.
// Depends on ebm_pkg for the state, command and status types.
module ebm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [ebm_pkg::CMD_W-1:0]     command,
	output logic                          in_ready,
	input  ebm_pkg::dp_stat_t             stat,
	output ebm_pkg::ctrl_cmd_t            cmd
);
	import ebm_pkg::*;

	state_t state_q, state_next;
	logic   accept;

	assign accept = in_valid && in_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && command == CMD_COMPUTE) begin
					state_next = ST_SETUP;
				end
			end
			ST_SETUP: begin
				if (stat.setup_last) begin
					state_next = stat.c_empty ? ST_DONE : ST_READ;
				end
			end
			ST_READ: begin
				state_next = stat.addr_err ? ST_DONE : ST_MUL1;
			end
			ST_MUL1: state_next = ST_MUL2;
			ST_MUL2: state_next = ST_ADD1;
			ST_ADD1: state_next = ST_ADD2;
			ST_ADD2: begin
				state_next = stat.c_last ? ST_DONE : ST_READ;
			end
			ST_DONE: begin
				if (!stat.out_busy) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.load  = accept;
				cmd.start = accept && command == CMD_COMPUTE;
			end
			ST_SETUP: cmd.setup = 1'b1;
			ST_READ:  cmd.read  = 1'b1;
			ST_MUL1:  cmd.mul1  = 1'b1;
			ST_MUL2:  cmd.mul2  = 1'b1;
			ST_ADD1:  cmd.add1  = 1'b1;
			ST_ADD2:  cmd.add2  = 1'b1;
			ST_DONE:  cmd.finish = !stat.out_busy;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- src/ebm_fpu.sv -----
// Single precision multiply and add with round to nearest even, two stages each.
// Depends on ebm_pkg for the command struct and word width.
module ebm_fpu (
	input  logic                        clk,
	input  ebm_pkg::ctrl_cmd_t          cmd,
	input  logic [ebm_pkg::WORD_W-1:0]  op_a,
	input  logic [ebm_pkg::WORD_W-1:0]  op_b,
	input  logic [ebm_pkg::WORD_W-1:0]  acc,
	output logic [ebm_pkg::WORD_W-1:0]  sum
);
	import ebm_pkg::*;

	localparam logic [31:0] QNAN_DEF = 32'hFFC0_0000;
	localparam logic [31:0] QUIET    = 32'h0040_0000;

	// Normalize, handle subnormal range, round and pack.
	// sig bit 49 weighs 1.0 at biased exponent exp.
	function automatic logic [31:0] fp_round(input logic sign,
			input logic signed [12:0] exp, input logic [49:0] sig);
		int                lz;
		int                sh;
		logic [49:0]       s;
		logic [49:0]       shd;
		logic              st;
		logic signed [12:0] e;
		logic [23:0]       m;
		logic              rnd;
		logic [32:0]       val;
		logic [31:0]       res;
		lz  = 0;
		sh  = 0;
		st  = 1'b0;
		shd = '0;
		for (int i = 0; i < 50; i++) begin
			if (sig[i]) lz = 49 - i;
		end
		s = sig << lz;
		e = exp - 13'(lz);
		if (e < 13'sd1) begin
			sh = 1 - int'(e);
			if (sh >= 50) begin
				shd = '0;
				st  = |s;
			end else begin
				shd = s >> sh;
				st  = |(s & ((50'd1 << sh) - 50'd1));
			end
			s = {shd[49:1], shd[0] | st};
			e = 13'sd1;
		end
		m   = s[49:26];
		rnd = s[25] && ((|s[24:0]) || m[0]);
		val = (33'(e - 13'sd1) << 23) + 33'(m) + 33'(rnd);
		if (sig == '0) begin
			res = {sign, 31'd0};
		end else if (val >= (33'd255 << 23)) begin
			res = {sign, 8'hFF, 23'd0};
		end else begin
			res = {sign, val[30:0]};
		end
		return res;
	endfunction

	// ---------------- multiply stage 1: specials and mantissa product
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic [23:0] ma, mb;
	logic [7:0]  ea_e, eb_e;
	logic        mul_special;
	logic [31:0] mul_spval;

	always_comb begin
		a_nan  = op_a[30:23] == 8'hFF && op_a[22:0] != '0;
		b_nan  = op_b[30:23] == 8'hFF && op_b[22:0] != '0;
		a_inf  = op_a[30:23] == 8'hFF && op_a[22:0] == '0;
		b_inf  = op_b[30:23] == 8'hFF && op_b[22:0] == '0;
		a_zero = op_a[30:0] == '0;
		b_zero = op_b[30:0] == '0;
		ma     = {op_a[30:23] != '0, op_a[22:0]};
		mb     = {op_b[30:23] != '0, op_b[22:0]};
		ea_e   = (op_a[30:23] == '0) ? 8'd1 : op_a[30:23];
		eb_e   = (op_b[30:23] == '0) ? 8'd1 : op_b[30:23];
		mul_special = 1'b1;
		if (a_nan) begin
			mul_spval = op_a | QUIET;
		end else if (b_nan) begin
			mul_spval = op_b | QUIET;
		end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
			mul_spval = QNAN_DEF;
		end else if (a_inf || b_inf) begin
			mul_spval = {op_a[31] ^ op_b[31], 8'hFF, 23'd0};
		end else begin
			mul_special = 1'b0;
			mul_spval   = '0;
		end
	end

	logic               mul_special_s1;
	logic [31:0]        mul_spval_s1;
	logic               mul_sign_s1;
	logic signed [12:0] mul_exp_s1;
	logic [47:0]        mul_prod_s1;

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			mul_special_s1 <= mul_special;
			mul_spval_s1   <= mul_spval;
			mul_sign_s1    <= op_a[31] ^ op_b[31];
			mul_exp_s1     <= 13'(ea_e) + 13'(eb_e) - 13'sd126;
			mul_prod_s1    <= ma * mb;
		end
	end

	// ---------------- multiply stage 2: round the product
	logic [31:0] prod_s2;

	always_ff @(posedge clk) begin
		if (cmd.mul2) begin
			prod_s2 <= mul_special_s1 ? mul_spval_s1
				: fp_round(mul_sign_s1, mul_exp_s1, {mul_prod_s1, 2'b00});
		end
	end

	// ---------------- add stage 1: align and add acc + product
	logic        x_nan, y_nan, x_inf, y_inf;
	logic        add_special;
	logic [31:0] add_spval;
	logic        swap;
	logic [31:0] big, small_op;
	logic [7:0]  eb_big, eb_small, d;
	logic [49:0] big_sig, small_full, small_shd, small_j, raw;
	logic        small_st;
	logic        res_sign;

	always_comb begin
		x_nan = acc[30:23] == 8'hFF && acc[22:0] != '0;
		y_nan = prod_s2[30:23] == 8'hFF && prod_s2[22:0] != '0;
		x_inf = acc[30:23] == 8'hFF && acc[22:0] == '0;
		y_inf = prod_s2[30:23] == 8'hFF && prod_s2[22:0] == '0;
		add_special = 1'b1;
		if (x_nan) begin
			add_spval = acc | QUIET;
		end else if (y_nan) begin
			add_spval = prod_s2 | QUIET;
		end else if (x_inf && y_inf && (acc[31] != prod_s2[31])) begin
			add_spval = QNAN_DEF;
		end else if (x_inf) begin
			add_spval = acc;
		end else if (y_inf) begin
			add_spval = prod_s2;
		end else begin
			add_special = 1'b0;
			add_spval   = '0;
		end

		// order operands by magnitude
		swap     = prod_s2[30:0] > acc[30:0];
		big      = swap ? prod_s2 : acc;
		small_op = swap ? acc : prod_s2;
		eb_big   = (big[30:23] == '0) ? 8'd1 : big[30:23];
		eb_small = (small_op[30:23] == '0) ? 8'd1 : small_op[30:23];
		d        = eb_big - eb_small;
		big_sig    = {1'b0, big[30:23] != '0, big[22:0], 25'd0};
		small_full = {1'b0, small_op[30:23] != '0, small_op[22:0], 25'd0};
		if (d >= 8'd50) begin
			small_shd = '0;
			small_st  = |small_full;
		end else begin
			small_shd = small_full >> d;
			small_st  = |(small_full & ((50'd1 << d) - 50'd1));
		end
		small_j = {small_shd[49:1], small_shd[0] | small_st};

		// add magnitudes or subtract the smaller one
		if (acc[31] == prod_s2[31]) begin
			raw      = big_sig + small_j;
			res_sign = acc[31];
		end else begin
			raw      = big_sig - small_j;
			res_sign = (raw == '0) ? 1'b0 : big[31];
		end
	end

	logic               add_special_s1;
	logic [31:0]        add_spval_s1;
	logic               add_sign_s1;
	logic signed [12:0] add_exp_s1;
	logic [49:0]        add_sig_s1;

	always_ff @(posedge clk) begin
		if (cmd.add1) begin
			add_special_s1 <= add_special;
			add_spval_s1   <= add_spval;
			add_sign_s1    <= res_sign;
			add_exp_s1     <= 13'(eb_big) + 13'sd1;
			add_sig_s1     <= raw;
		end
	end

	// ---------------- add stage 2: round the sum
	assign sum = add_special_s1 ? add_spval_s1
		: fp_round(add_sign_s1, add_exp_s1, add_sig_s1);

endmodule

// ----- src/ebm_dp.sv -----
// Datapath: configuration registers, operand stores, address generation,
// accumulator and result register. Depends on ebm_pkg and ebm_fpu.
module ebm_dp #(
	parameter int STORE_DEPTH = ebm_pkg::STORE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ebm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ebm_pkg::SIZE_W-1:0]      cfg_data,
	input  logic [ebm_pkg::CMD_W-1:0]       command,
	input  logic [ebm_pkg::LADDR_W-1:0]     load_address,
	input  logic [ebm_pkg::WORD_W-1:0]      load_value,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_batch,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_group,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_row,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_col,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_out,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [ebm_pkg::WORD_W-1:0]      result_value,
	output logic                            range_error,
	input  ebm_pkg::ctrl_cmd_t              cmd,
	output ebm_pkg::dp_stat_t               stat
);
	import ebm_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);

	// ---------------- configuration registers
	logic              mode_q;
	logic [SIZE_W-1:0] size_b_q, size_m_q, size_c_q, size_h_q, size_w_q, size_n_q;
	logic [SIZE_W-1:0] size_clamped;

	assign size_clamped = (int'(cfg_data) > DIM_MAX_DEF) ? SIZE_W'(DIM_MAX_DEF) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_BMCHW;
			size_b_q <= SIZE_W'(1);
			size_m_q <= SIZE_W'(1);
			size_c_q <= SIZE_W'(1);
			size_h_q <= SIZE_W'(1);
			size_w_q <= SIZE_W'(1);
			size_n_q <= SIZE_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[0];
				REG_SIZE_B: size_b_q <= size_clamped;
				REG_SIZE_M: size_m_q <= size_clamped;
				REG_SIZE_C: size_c_q <= size_clamped;
				REG_SIZE_H: size_h_q <= size_clamped;
				REG_SIZE_W: size_w_q <= size_clamped;
				REG_SIZE_N: size_n_q <= size_clamped;
				default: ;
			endcase
		end
	end

	// ---------------- operand stores
	logic [WORD_W-1:0] mem_a [STORE_DEPTH];
	logic [WORD_W-1:0] mem_b [STORE_DEPTH];
	logic [WORD_W-1:0] rd_a_q, rd_b_q;
	logic [AW-1:0]     wr_idx;
	logic              wr_ok;
	logic [WIDE_W-1:0] addr_a_q, addr_b_q;

	assign wr_idx = AW'(load_address);
	assign wr_ok  = 32'(load_address) < 32'(STORE_DEPTH);

	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok && command == CMD_LOAD_A) begin
			mem_a[wr_idx] <= load_value;
		end
		if (cmd.read) begin
			rd_a_q <= mem_a[addr_a_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && wr_ok && command == CMD_LOAD_B) begin
			mem_b[wr_idx] <= load_value;
		end
		if (cmd.read) begin
			rd_b_q <= mem_b[addr_b_q[AW-1:0]];
		end
	end

	// ---------------- address setup: acc = acc * size + index, four steps
	logic [IDX_W-1:0]    g_q, h_q, w_q, n_q;
	logic [1:0]          step_q;
	logic [SIZE_W-1:0]   fa, fb;
	logic [IDX_W-1:0]    ga, gb;
	logic [STRIDE_W-1:0] stride_a;

	assign stride_a = STRIDE_W'(size_h_q) * STRIDE_W'(size_w_q);

	always_comb begin
		fa = SIZE_W'(1);
		ga = '0;
		fb = SIZE_W'(1);
		gb = '0;
		if (mode_q == MODE_BMCHW) begin
			case (step_q)
				2'd0: begin fa = size_m_q; ga = g_q; fb = size_n_q; gb = n_q; end
				2'd1: begin fa = size_c_q;           fb = size_m_q; gb = g_q; end
				2'd2: begin fa = size_h_q; ga = h_q; fb = size_c_q;           end
				default: begin fa = size_w_q; ga = w_q; end
			endcase
		end else begin
			case (step_q)
				2'd0: begin fa = size_c_q;           fb = size_m_q; gb = g_q; end
				2'd1: begin fa = size_h_q; ga = h_q; fb = size_c_q;           end
				2'd2: begin fa = size_w_q; ga = w_q;                          end
				default: ;
			endcase
		end
	end

	// ---------------- per-term counter, error flag and accumulator
	logic [CNT_W-1:0]  c_q;
	logic              err_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] fpu_sum;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			g_q <= idx_group;
			h_q <= idx_row;
			w_q <= idx_col;
			n_q <= idx_out;
			addr_a_q <= WIDE_W'(idx_batch);
			addr_b_q <= WIDE_W'(idx_batch);
			acc_q    <= '0;
		end else if (cmd.setup) begin
			addr_a_q <= WIDE_W'(addr_a_q * WIDE_W'(fa) + WIDE_W'(ga));
			addr_b_q <= WIDE_W'(addr_b_q * WIDE_W'(fb) + WIDE_W'(gb));
		end else if (cmd.read) begin
			// advance to the next channel
			addr_a_q <= addr_a_q + WIDE_W'(stride_a);
			addr_b_q <= addr_b_q + WIDE_W'(1);
		end else if (cmd.add2) begin
			acc_q <= fpu_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			c_q    <= '0;
			err_q  <= 1'b0;
		end else if (cmd.start) begin
			step_q <= '0;
			c_q    <= '0;
			err_q  <= 1'b0;
		end else begin
			if (cmd.setup) step_q <= step_q + 2'd1;
			if (cmd.read && stat.addr_err) err_q <= 1'b1;
			if (cmd.add2) c_q <= c_q + CNT_W'(1);
		end
	end

	ebm_fpu u_fpu (
		.clk  (clk),
		.cmd  (cmd),
		.op_a (rd_a_q),
		.op_b (rd_b_q),
		.acc  (acc_q),
		.sum  (fpu_sum)
	);

	// ---------------- result register
	logic              out_valid_q;
	logic [WORD_W-1:0] res_value_q;
	logic              res_err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_value_q <= err_q ? '0 : acc_q;
			res_err_q   <= err_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_value_q;
	assign range_error  = res_err_q;

	// ---------------- status
	always_comb begin
		stat.setup_last = step_q == SETUP_LAST;
		stat.c_empty    = size_c_q == '0;
		stat.c_last     = (8'(c_q) + 8'd1) == 8'(size_c_q);
		stat.addr_err   = (addr_a_q >= WIDE_W'(STORE_DEPTH))
			|| (addr_b_q >= WIDE_W'(STORE_DEPTH));
		stat.out_busy   = out_valid_q && !out_ready;
	end

endmodule

// ----- src/einsum_batched_matmul.sv -----
// Batched einsum matrix multiply on single floats, top level.
// Depends on ebm_pkg, ebm_ctrl and ebm_dp.
//
// Load items (command 0 or 1) write one word into operand store A or B and are
// taken in the idle state, with no result. A compute item (command 2) returns
// one dot product over the channel dimension, summed in ascending channel order
// with each product and sum rounded to nearest even. It runs address setup,
// then per channel one store read, two multiply stages and two add stages,
// since each add waits for the previous sum; then the result register is loaded
// once no earlier result is stalled at the output. An operand address past the
// store depth ends the item early with range_error set and a zero value. A new
// item is taken while the last result still waits at the output.
module einsum_batched_matmul #(
	parameter int STORE_DEPTH = ebm_pkg::STORE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ebm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ebm_pkg::SIZE_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [ebm_pkg::CMD_W-1:0]       command,
	input  logic [ebm_pkg::LADDR_W-1:0]     load_address,
	input  logic [ebm_pkg::WORD_W-1:0]      load_value,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_batch,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_group,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_row,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_col,
	input  logic [ebm_pkg::IDX_W-1:0]       idx_out,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [ebm_pkg::WORD_W-1:0]      result_value,
	output logic                            range_error
);
	import ebm_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ebm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ebm_dp #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.load_address (load_address),
		.load_value   (load_value),
		.idx_batch    (idx_batch),
		.idx_group    (idx_group),
		.idx_row      (idx_row),
		.idx_col      (idx_col),
		.idx_out      (idx_out),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.result_value (result_value),
		.range_error  (range_error),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule

// ----- src/ebm_checker.sv -----
// Port-level checks for the batched einsum block, bound to the top level.
// Depends on ebm_pkg for command codes and field widths.
module ebm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [ebm_pkg::CMD_W-1:0]       command,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ebm_pkg::WORD_W-1:0]      result_value,
	input logic                            range_error
);
	import ebm_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value)
			&& $stable(range_error))
		else $error("result changed while stalled");

	// Drop the value on an address error
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> result_value == '0)
		else $error("range error with nonzero value");

	// A load transaction causes no result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command != CMD_COMPUTE && !out_valid |=> !out_valid)
		else $error("result after a load");

	// A compute transaction occupies the block
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_COMPUTE |=> !in_ready)
		else $error("input taken during compute");

endmodule

bind einsum_batched_matmul ebm_checker u_ebm_checker (.*);

// ----- tb/ebm_checker.sv -----
// Checker for the batched einsum matrix multiply block: watches the config port
// and both channels, predicts every dot product and compares each result.
// Depends on ebm_pkg only.
module tb_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [ebm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ebm_pkg::SIZE_W-1:0]    cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [ebm_pkg::CMD_W-1:0]     command,
	input  logic [ebm_pkg::LADDR_W-1:0]   load_address,
	input  logic [ebm_pkg::WORD_W-1:0]    load_value,
	input  logic [ebm_pkg::IDX_W-1:0]     idx_batch,
	input  logic [ebm_pkg::IDX_W-1:0]     idx_group,
	input  logic [ebm_pkg::IDX_W-1:0]     idx_row,
	input  logic [ebm_pkg::IDX_W-1:0]     idx_col,
	input  logic [ebm_pkg::IDX_W-1:0]     idx_out,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [ebm_pkg::WORD_W-1:0]    result_value,
	input  logic                          range_error,
	output int                            pending,
	output int                            fails
);
	timeunit 1ns;
	timeprecision 1ps;
	import ebm_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              err;
	} dot_t;

	logic [WORD_W-1:0] a_words [STORE_DEPTH_DEF];
	logic [WORD_W-1:0] b_words [STORE_DEPTH_DEF];
	logic              layout;
	longint unsigned   dim_b, dim_m, dim_c, dim_h, dim_w, dim_n;
	dot_t              dots_due [$];

	// Widen single float bits to a real without loss
	function automatic real f32_to_real(logic [31:0] u);
		real r;
		if (u[30:23] == 8'hFF)
			return $bitstoreal({u[31], 11'h7FF, u[22:0], 29'b0});
		if (u[30:23] == 8'h00) begin
			if (u[22:0] == 0)
				return $bitstoreal({u[31], 63'b0});
			r = real'(u[22:0]) * (2.0 ** -149);
			return u[31] ? -r : r;
		end
		return $bitstoreal({u[31], 11'(int'(u[30:23]) - 127 + 1023), u[22:0], 29'b0});
	endfunction

	// Round a real to single precision, nearest even, subnormals kept
	function automatic logic [31:0] real_to_f32(real r);
		logic [63:0] d, sig, kept, rem, half;
		int          e, sh;
		d = $realtobits(r);
		if (d[62:52] == 11'h7FF)
			return {d[63], 8'hFF, (d[51:0] != 0) ? {1'b1, d[50:29]} : 23'b0};
		if (d[62:52] == 0)
			return {d[63], 31'b0};
		e   = int'(d[62:52]) - 1023 + 127;
		sig = {11'b0, 1'b1, d[51:0]};
		sh  = (e >= 1) ? 29 : 29 + 1 - e;
		if (sh > 60)
			return {d[63], 31'b0};
		kept = sig >> sh;
		rem  = sig & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && kept[0]))
			kept = kept + 1;
		if (e >= 1) begin
			if (kept[24]) begin
				kept = kept >> 1;
				e = e + 1;
			end
			if (e >= 255)
				return {d[63], 8'hFF, 23'b0};
			return {d[63], e[7:0], kept[22:0]};
		end
		return {d[63], kept[30:0]};
	endfunction

	function automatic longint unsigned clamp_dim(logic [SIZE_W-1:0] v);
		return (v > DIM_MAX_DEF) ? DIM_MAX_DEF : v;
	endfunction

	// Dot product over c for one output element
	function automatic dot_t predict_dot(longint unsigned b, g, h, w, n);
		dot_t            res;
		longint unsigned aa, ba;
		logic [31:0]     acc, prod;
		acc = 32'h0;
		for (longint unsigned c = 0; c < dim_c; c++) begin
			if (layout == MODE_BMCHW) begin
				aa = (((b * dim_m + g) * dim_c + c) * dim_h + h) * dim_w + w;
				ba = ((b * dim_n + n) * dim_m + g) * dim_c + c;
			end else begin
				aa = ((b * dim_c + c) * dim_h + h) * dim_w + w;
				ba = (b * dim_m + g) * dim_c + c;
			end
			if (aa >= STORE_DEPTH_DEF || ba >= STORE_DEPTH_DEF) begin
				res.value = '0;
				res.err   = 1'b1;
				return res;
			end
			prod = real_to_f32(f32_to_real(a_words[aa]) * f32_to_real(b_words[ba]));
			acc  = real_to_f32(f32_to_real(acc) + f32_to_real(prod));
		end
		res.value = acc;
		res.err   = 1'b0;
		return res;
	endfunction

	assign pending = dots_due.size();

	// Track config, predict accepted transactions, compare results
	always @(posedge clk or negedge arst_n) begin
		dot_t got;
		if (!arst_n) begin
			layout = MODE_BMCHW;
			dim_b = 1; dim_m = 1; dim_c = 1; dim_h = 1; dim_w = 1; dim_n = 1;
			fails = 0;
			dots_due.delete();
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_MODE:   layout = cfg_data[0];
					REG_SIZE_B: dim_b = clamp_dim(cfg_data);
					REG_SIZE_M: dim_m = clamp_dim(cfg_data);
					REG_SIZE_C: dim_c = clamp_dim(cfg_data);
					REG_SIZE_H: dim_h = clamp_dim(cfg_data);
					REG_SIZE_W: dim_w = clamp_dim(cfg_data);
					REG_SIZE_N: dim_n = clamp_dim(cfg_data);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (dots_due.size() == 0) begin
					$error("unexpected result transaction: value %h err %b",
						result_value, range_error);
					fails++;
				end else begin
					got = dots_due.pop_front();
					if (result_value !== got.value) begin
						$error("result_value: expected %h, actual %h", got.value, result_value);
						fails++;
					end
					if (range_error !== got.err) begin
						$error("range_error: expected %b, actual %b", got.err, range_error);
						fails++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (command)
					CMD_LOAD_A:  a_words[load_address] = load_value;
					CMD_LOAD_B:  b_words[load_address] = load_value;
					CMD_COMPUTE: dots_due.push_back(predict_dot(idx_batch, idx_group,
						idx_row, idx_col, idx_out));
					default: ;
				endcase
			end
		end
	end
endmodule

// ----- tb/tb_top.sv -----
// Testbench top for einsum_batched_matmul: clock, reset, config writes,
// load and compute stimulus with random idling, watchdog and verdict.
// Depends on ebm_pkg, tb_checker and the block itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ebm_pkg::*;

	localparam int HUSH_LIMIT = 6000;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 cfg_write = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0]    cfg_data = '0;
	logic                 in_valid = 0;
	logic                 in_ready;
	logic [CMD_W-1:0]     command = '0;
	logic [LADDR_W-1:0]   load_address = '0;
	logic [WORD_W-1:0]    load_value = '0;
	logic [IDX_W-1:0]     idx_batch = '0, idx_group = '0, idx_row = '0;
	logic [IDX_W-1:0]     idx_col = '0, idx_out = '0;
	logic                 out_valid;
	logic                 out_ready = 0;
	logic [WORD_W-1:0]    result_value;
	logic                 range_error;
	int                   pending, fails;

	// Stimulus-side view of config and of written store entries
	logic            shadow_mode;
	longint unsigned shadow_dim [7];
	bit              a_set [STORE_DEPTH_DEF];
	bit              b_set [STORE_DEPTH_DEF];
	int              items_sent;
	bit              no_gaps;
	int              hush = 0;

	always #1 clk = ~clk;

	einsum_batched_matmul uut (.*);
	tb_checker u_checker (.*);

	// Watchdog: cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			hush <= 0;
		else if (hush >= HUSH_LIMIT) begin
			$display("einsum_batched_matmul: mismatch");
			$finish;
		end else
			hush <= hush + 1;
	end

	// Result side: random stalls, one long hold-off to back up the block
	initial begin
		int taken;
		bit seen;
		taken = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready = 0;
			if (taken == 40)
				repeat (500) @(negedge clk);
			else if (!no_gaps)
				repeat ($urandom_range(0, 17)) @(negedge clk);
			out_ready = 1;
			seen = out_valid;
			@(posedge clk);
			while (!seen) begin
				@(negedge clk);
				seen = out_valid;
				@(posedge clk);
			end
			taken++;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
		@(negedge clk);
		cfg_write = 1;
		cfg_index = idx;
		cfg_data  = data;
		if (idx == REG_MODE)
			shadow_mode = data[0];
		else
			shadow_dim[idx] = (data > DIM_MAX_DEF) ? DIM_MAX_DEF : data;
		@(negedge clk);
		cfg_write = 0;
	endtask

	// Offer one transaction and hold it until accepted
	task automatic offer(logic [CMD_W-1:0] cmd, logic [LADDR_W-1:0] addr,
			logic [WORD_W-1:0] val, logic [IDX_W-1:0] b, g, h, w, n);
		bit rdy;
		if (!no_gaps)
			repeat ($urandom_range(0, 17)) @(negedge clk);
		in_valid = 1;
		command = cmd; load_address = addr; load_value = val;
		idx_batch = b; idx_group = g; idx_row = h; idx_col = w; idx_out = n;
		rdy = in_ready;
		@(posedge clk);
		while (!rdy) begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end
		@(negedge clk);
		in_valid = 0;
		if (cmd == CMD_LOAD_A) a_set[addr] = 1;
		if (cmd == CMD_LOAD_B) b_set[addr] = 1;
		if (cmd != CMD_UNUSED) items_sent++;
	endtask

	// True if a compute reads only written entries before any range error
	function automatic bit reads_written(longint unsigned b, g, h, w, n);
		longint unsigned aa, ba, dm, dc, dh, dw, dn;
		dm = shadow_dim[REG_SIZE_M]; dc = shadow_dim[REG_SIZE_C];
		dh = shadow_dim[REG_SIZE_H]; dw = shadow_dim[REG_SIZE_W];
		dn = shadow_dim[REG_SIZE_N];
		for (longint unsigned c = 0; c < dc; c++) begin
			if (shadow_mode == MODE_BMCHW) begin
				aa = (((b * dm + g) * dc + c) * dh + h) * dw + w;
				ba = ((b * dn + n) * dm + g) * dc + c;
			end else begin
				aa = ((b * dc + c) * dh + h) * dw + w;
				ba = (b * dm + g) * dc + c;
			end
			if (aa >= STORE_DEPTH_DEF || ba >= STORE_DEPTH_DEF)
				return 1;
			if (!a_set[aa] || !b_set[ba])
				return 0;
		end
		return 1;
	endfunction

	task automatic try_compute(logic [IDX_W-1:0] b, g, h, w, n);
		if (reads_written(b, g, h, w, n))
			offer(CMD_COMPUTE, '0, $urandom, b, g, h, w, n);
	endtask

	function automatic logic [31:0] pick_float();
		case ($urandom_range(0, 9))
			0: return {$urandom_range(0, 1) == 1, 31'b0};
			1: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
			default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(107, 147)),
				23'($urandom)};
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] pick_idx(int reg_idx, bit wide);
		if (wide || shadow_dim[reg_idx] == 0)
			return IDX_W'($urandom_range(0, 63));
		return IDX_W'($urandom_range(0, int'(shadow_dim[reg_idx]) - 1));
	endfunction

	// Wait for all results, let the block settle, then set all registers
	task automatic set_layout(logic m, logic [SIZE_W-1:0] sb, sm, sc, sh, sw, sn);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		write_reg(REG_MODE, {6'b0, m});
		write_reg(REG_SIZE_B, sb);
		write_reg(REG_SIZE_M, sm);
		write_reg(REG_SIZE_C, sc);
		write_reg(REG_SIZE_H, sh);
		write_reg(REG_SIZE_W, sw);
		write_reg(REG_SIZE_N, sn);
	endtask

	// Fill the leading part of both tensors
	task automatic fill_tensors();
		longint unsigned na, nb, d[7];
		d = shadow_dim;
		if (shadow_mode == MODE_BMCHW) begin
			na = d[REG_SIZE_B] * d[REG_SIZE_M] * d[REG_SIZE_C] * d[REG_SIZE_H] * d[REG_SIZE_W];
			nb = d[REG_SIZE_B] * d[REG_SIZE_N] * d[REG_SIZE_M] * d[REG_SIZE_C];
		end else begin
			na = d[REG_SIZE_B] * d[REG_SIZE_C] * d[REG_SIZE_H] * d[REG_SIZE_W];
			nb = d[REG_SIZE_B] * d[REG_SIZE_M] * d[REG_SIZE_C];
		end
		if (na > 260) na = 260;
		if (nb > 260) nb = 260;
		for (int i = 0; i < na; i++)
			offer(CMD_LOAD_A, LADDR_W'(i), pick_float(), 0, 0, 0, 0, 0);
		for (int i = 0; i < nb; i++)
			offer(CMD_LOAD_B, LADDR_W'(i), pick_float(), 0, 0, 0, 0, 0);
	endtask

	// Mostly computes, with stray loads and unused commands mixed in
	task automatic mixed_traffic(int count);
		int  r;
		bit  wide;
		repeat (count) begin
			r = $urandom_range(0, 19);
			wide = ($urandom_range(0, 4) == 0);
			if (r < 15)
				try_compute(pick_idx(REG_SIZE_B, wide), pick_idx(REG_SIZE_M, wide),
					pick_idx(REG_SIZE_H, wide), pick_idx(REG_SIZE_W, wide),
					pick_idx(REG_SIZE_N, wide));
			else if (r < 18)
				offer(2'($urandom_range(0, 1)), LADDR_W'($urandom_range(0, 300)),
					pick_float(), 0, 0, 0, 0, 0);
			else if (r < 19)
				offer(2'($urandom_range(0, 1)), 12'($urandom), $urandom, 0, 0, 0, 0, 0);
			else
				offer(CMD_UNUSED, 12'($urandom), $urandom, IDX_W'($urandom),
					IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom),
					IDX_W'($urandom));
		end
	endtask

	function automatic logic [SIZE_W-1:0] pick_size();
		return ($urandom_range(0, 5) == 0) ? SIZE_W'($urandom_range(5, 64))
			: SIZE_W'($urandom_range(1, 4));
	endfunction

	initial begin
		shadow_mode = MODE_BMCHW;
		foreach (shadow_dim[i]) shadow_dim[i] = 1;
		items_sent = 0;
		no_gaps = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;

		// Reset sizes: single product, then an index far out of range
		offer(CMD_LOAD_A, 0, 32'h3FC00000, 0, 0, 0, 0, 0);
		offer(CMD_LOAD_B, 0, 32'hC0000000, 0, 0, 0, 0, 0);
		try_compute(0, 0, 0, 0, 0);
		try_compute(63, 63, 63, 63, 63);
		offer(CMD_UNUSED, 12'hFFF, 32'hFFFFFFFF, 6'h3F, 6'h3F, 6'h3F, 6'h3F, 6'h3F);

		// Overflow to infinity, then an all-ones word overwritten before use
		offer(CMD_LOAD_A, 0, 32'h7F7FFFFF, 0, 0, 0, 0, 0);
		offer(CMD_LOAD_B, 0, 32'h40000000, 0, 0, 0, 0, 0);
		try_compute(0, 0, 0, 0, 0);
		offer(CMD_LOAD_A, 12'hFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0);
		offer(CMD_LOAD_A, 12'hFFF, 32'h00000001, 0, 0, 0, 0, 0);

		// Small layout in BMCHW mode, corners of the index space
		set_layout(MODE_BMCHW, 2, 2, 3, 2, 2, 2);
		fill_tensors();
		try_compute(0, 0, 0, 0, 0);
		try_compute(1, 1, 1, 1, 1);
		try_compute(1, 0, 1, 0, 1);

		// Channel size saturates at the maximum
		set_layout(MODE_BCHW, 1, 2, 7'd127, 1, 1, 7'd127);
		fill_tensors();
		try_compute(0, 1, 0, 0, 63);

		// Zero channel size gives an empty sum
		set_layout(MODE_BCHW, 0, 0, 0, 0, 0, 0);
		try_compute(0, 0, 0, 0, 0);
		try_compute(63, 63, 63, 63, 63);

		// Random layouts, some of them run with no idling at all
		while (items_sent < 1850) begin
			set_layout(1'($urandom_range(0, 1)), pick_size(), pick_size(), pick_size(),
				pick_size(), pick_size(), pick_size());
			no_gaps = ($urandom_range(0, 3) == 0);
			fill_tensors();
			mixed_traffic(120);
			no_gaps = 0;
		end

		while (pending != 0) @(negedge clk);
		repeat (400) @(negedge clk);
		if (fails == 0)
			$display("einsum_batched_matmul: match");
		else
			$display("einsum_batched_matmul: mismatch");
		$finish;
	end
endmodule
